@@ sv/i2ctrb_pkg.sv @@
`timescale 1ns / 1ps

package i2ctrb_pkg;

  localparam int unsigned BUFFER_DEPTH_DEF = 255;
  localparam int unsigned APB_AW           = 3;
  localparam int unsigned APB_DW           = 32;

  localparam logic [7:0] PTR_NONE = 8'hFF;

  typedef enum logic [2:0] {
    REQ_ADDR_WR = 3'd0,
    REQ_BYTE_RX = 3'd1,
    REQ_ADDR_RD = 3'd2,
    REQ_BYTE_TX = 3'd3,
    REQ_OTHER   = 3'd4,
    REQ_HOST_WR = 3'd5,
    REQ_HOST_RD = 3'd6
  } req_e;

  typedef enum logic {
    REG_OWN_ADDR = 1'b0,
    REG_ENABLE   = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [6:0] own_address;
    logic       enable;
  } cfg_t;

  typedef struct packed {
    logic       ce;
    logic       we;
    logic       re;
    logic [7:0] waddr;
    logic [7:0] wdata;
    logic [7:0] raddr;
  } store_ctl_t;

endpackage

@@ sv/i2ctrb_if.sv @@
`timescale 1ns / 1ps

interface i2ctrb_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] data;
  logic [7:0] host_index;

  modport source (output valid, req_type, data, host_index, input ready);
  modport sink   (input valid, req_type, data, host_index, output ready);
endinterface

interface i2ctrb_rsp_if;
  logic       valid;
  logic       ready;
  logic       ack;
  logic [7:0] tx_byte;
  logic [7:0] host_read_data;
  logic [7:0] pointer_now;

  modport source (output valid, ack, tx_byte, host_read_data, pointer_now, input ready);
  modport sink   (input valid, ack, tx_byte, host_read_data, pointer_now, output ready);
endinterface

@@ sv/i2ctrb_store.sv @@
`timescale 1ns / 1ps

module i2ctrb_store
  import i2ctrb_pkg::*;
#(
  parameter int unsigned DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  store_ctl_t ctl_i,
  output logic [7:0] rdata_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [7:0]       rdata_q;
  logic             hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      hit_q <= 1'b0;
    end else begin
      if (ctl_i.we) begin
        vld_q[ctl_i.waddr[AW-1:0]] <= 1'b1;
      end
      if (ctl_i.ce) begin
        hit_q <= ctl_i.re && vld_q[ctl_i.raddr[AW-1:0]];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[ctl_i.waddr[AW-1:0]] <= ctl_i.wdata;
    end
    if (ctl_i.ce) begin
      rdata_q <= mem[ctl_i.raddr[AW-1:0]];
    end
  end

  assign rdata_o = hit_q ? rdata_q : 8'h00;

endmodule

@@ sv/i2ctrb_cfg.sv @@
`timescale 1ns / 1ps

module i2ctrb_cfg
  import i2ctrb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_d, cfg_q;
  cfg_reg_e sel;
  logic     wr;

  assign sel    = cfg_reg_e'(paddr[2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (sel)
        REG_OWN_ADDR: cfg_d.own_address = pwdata[6:0];
        REG_ENABLE:   cfg_d.enable      = pwdata[0];
        default:      cfg_d             = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_OWN_ADDR: prdata = {{(APB_DW-7){1'b0}}, cfg_q.own_address};
      REG_ENABLE:   prdata = {{(APB_DW-1){1'b0}}, cfg_q.enable};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/i2c_target_register_buffer.sv @@
// Throughput: one event per cycle unless responses stall, set by the pointer update and
// store port. Requests go from the input stage to the output stage when it is free.
// Store reads are synchronous and land directly in the response register.
// Reset (rst_ni low, asynchronous): pointer to none selected, stores read as zero,
// enable and own address cleared, both pipeline stages empty.
`timescale 1ns / 1ps

module i2c_target_register_buffer
  import i2ctrb_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  i2ctrb_req_if.sink        req_i,
  i2ctrb_rsp_if.source      rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam logic [7:0] DEPTH8 = 8'(BUFFER_DEPTH);

  cfg_t       cfg;
  store_ctl_t rx_ctl, tx_ctl;

  logic       in_valid_q;
  logic [2:0] type_q;
  logic [7:0] data_q, hidx_q;
  logic       out_valid_q;
  logic       ack_d, ack_q;
  logic [7:0] ptr_d, ptr_q, ptr_out_q;
  logic [7:0] ptr_inc;
  logic       adv;
  logic       rx_we, tx_we, rx_re, tx_re;

  i2ctrb_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign adv         = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || adv;
  assign ptr_inc     = ptr_q + 8'd1;

  always_comb begin
    ptr_d = ptr_q;
    ack_d = 1'b0;
    rx_we = 1'b0;
    tx_we = 1'b0;
    rx_re = 1'b0;
    tx_re = 1'b0;
    unique case (req_e'(type_q)) inside
      REQ_HOST_WR: tx_we = hidx_q < DEPTH8;
      REQ_HOST_RD: rx_re = hidx_q < DEPTH8;
      REQ_ADDR_WR: begin
        if (cfg.enable) begin
          ptr_d = PTR_NONE;
          ack_d = 1'b1;
        end
      end
      REQ_BYTE_RX: begin
        if (cfg.enable) begin
          if (ptr_q == PTR_NONE) begin
            ptr_d = data_q;
            ack_d = 1'b1;
          end else begin
            rx_we = ptr_q < DEPTH8;
            ptr_d = ptr_inc;
            ack_d = ptr_inc < DEPTH8;
          end
        end
      end
      REQ_ADDR_RD, REQ_BYTE_TX: begin
        if (cfg.enable) begin
          tx_re = ptr_q < DEPTH8;
          ptr_d = (ptr_q == PTR_NONE) ? PTR_NONE : ptr_inc;
          ack_d = ((ptr_q == PTR_NONE) ? PTR_NONE : ptr_inc) < DEPTH8;
        end
      end
      default: ack_d = cfg.enable;
    endcase
  end

  always_comb begin
    rx_ctl       = '0;
    rx_ctl.ce    = adv;
    rx_ctl.we    = adv && rx_we;
    rx_ctl.re    = rx_re;
    rx_ctl.waddr = ptr_q;
    rx_ctl.wdata = data_q;
    rx_ctl.raddr = hidx_q;
    tx_ctl       = '0;
    tx_ctl.ce    = adv;
    tx_ctl.we    = adv && tx_we;
    tx_ctl.re    = tx_re;
    tx_ctl.waddr = hidx_q;
    tx_ctl.wdata = data_q;
    tx_ctl.raddr = ptr_q;
  end

  i2ctrb_store #(.DEPTH(BUFFER_DEPTH)) u_rx_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (rx_ctl),
    .rdata_o (rsp_o.host_read_data)
  );

  i2ctrb_store #(.DEPTH(BUFFER_DEPTH)) u_tx_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (tx_ctl),
    .rdata_o (rsp_o.tx_byte)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ptr_q       <= PTR_NONE;
    end else begin
      if (req_i.ready) begin
        in_valid_q <= req_i.valid;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
        ptr_q       <= ptr_d;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      type_q <= req_i.req_type;
      data_q <= req_i.data;
      hidx_q <= req_i.host_index;
    end
    if (adv) begin
      ack_q     <= ack_d;
      ptr_out_q <= ptr_d;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.ack         = ack_q;
  assign rsp_o.pointer_now = ptr_out_q;

endmodule

@@ sv/i2ctrb_checker.sv @@
`timescale 1ns / 1ps

module i2ctrb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic       rsp_ack_i,
  input logic [7:0] rsp_tx_byte_i,
  input logic [7:0] rsp_host_read_data_i,
  input logic [7:0] rsp_pointer_now_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_ack_i)
      && $stable(rsp_tx_byte_i) && $stable(rsp_host_read_data_i)
      && $stable(rsp_pointer_now_i))
    else $error("response changed while stalled");

  a_req_to_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |-> ##2 rsp_valid_i)
    else $error("accepted transaction produced no response");

  a_ack_no_host: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_ack_i |-> rsp_host_read_data_i == 8'h00)
    else $error("acknowledge on host read");

  a_tx_no_host: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_tx_byte_i != 8'h00 |-> rsp_host_read_data_i == 8'h00)
    else $error("bus byte and host data in one response");

endmodule

bind i2c_target_register_buffer i2ctrb_checker u_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .req_valid_i          (req_i.valid),
  .req_ready_i          (req_i.ready),
  .rsp_valid_i          (rsp_o.valid),
  .rsp_ready_i          (rsp_o.ready),
  .rsp_ack_i            (rsp_o.ack),
  .rsp_tx_byte_i        (rsp_o.tx_byte),
  .rsp_host_read_data_i (rsp_o.host_read_data),
  .rsp_pointer_now_i    (rsp_o.pointer_now)
);

@@ verif/tb_i2c_target_register_buffer.sv @@
`timescale 1ns / 1ps

module tb_i2c_target_register_buffer
  import i2ctrb_pkg::*;
();

  localparam int unsigned DEPTH      = BUFFER_DEPTH_DEF;
  localparam int unsigned QUIET_MAX  = 4000;
  localparam int unsigned SHOW_MAX   = 10;
  localparam int unsigned IDLE_PCT   = 35;

  typedef struct packed {
    logic       ack;
    logic [7:0] tx_byte;
    logic [7:0] host_read_data;
    logic [7:0] pointer_now;
  } event_rsp_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  i2ctrb_req_if req_if ();
  i2ctrb_rsp_if rsp_if ();

  i2c_target_register_buffer DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow of the block's state
  logic [7:0] ptr_q;
  logic [7:0] rx_mem [DEPTH];
  logic [7:0] tx_mem [DEPTH];
  logic [6:0] own_addr_q;
  logic       bus_en_q;

  event_rsp_t  pending_rsp [$];
  bit          calm;
  int unsigned mismatches;
  int unsigned events_sent;
  int unsigned rsp_checked;
  int unsigned cfg_writes;
  int unsigned quiet_cycles;
  int unsigned kind_count [8];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic event_rsp_t apply_bus_event(req_e kind, logic [7:0] d, logic [7:0] idx);
    event_rsp_t r;
    r = '0;
    case (kind)
      REQ_HOST_WR: begin
        if (idx < DEPTH) tx_mem[idx] = d;
      end
      REQ_HOST_RD: begin
        if (idx < DEPTH) r.host_read_data = rx_mem[idx];
      end
      default: begin
        if (bus_en_q) begin
          case (kind)
            REQ_ADDR_WR: begin
              ptr_q = PTR_NONE;
              r.ack = 1'b1;
            end
            REQ_BYTE_RX: begin
              if (ptr_q == PTR_NONE) begin
                ptr_q = d;
                r.ack = 1'b1;
              end else begin
                if (ptr_q < DEPTH) rx_mem[ptr_q] = d;
                ptr_q = ptr_q + 8'd1;
                r.ack = (ptr_q < DEPTH);
              end
            end
            REQ_ADDR_RD, REQ_BYTE_TX: begin
              if (ptr_q < DEPTH) r.tx_byte = tx_mem[ptr_q];
              if (ptr_q != PTR_NONE) ptr_q = ptr_q + 8'd1;
              r.ack = (ptr_q < DEPTH);
            end
            default: r.ack = 1'b1;
          endcase
        end
      end
    endcase
    r.pointer_now = ptr_q;
    return r;
  endfunction

  function automatic void note_mismatch(string what, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= SHOW_MAX)
      $display("tb: mismatch on %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $time);
  endfunction

  // bias toward both ends of the store
  function automatic logic [7:0] pick_index();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 40) return 8'($urandom_range(15));
    if (sel < 80) return 8'($urandom_range(DEPTH - 1, DEPTH - 16));
    return 8'($urandom_range(DEPTH - 1));
  endfunction

  task automatic send_event(req_e kind, logic [7:0] d, logic [7:0] idx);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.req_type   <= kind;
    req_if.data       <= d;
    req_if.host_index <= idx;
    do @(posedge clk_i); while (!req_if.ready);
    pending_rsp.push_back(apply_bus_event(kind, d, idx));
    events_sent++;
    kind_count[kind]++;
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic apb_write(cfg_reg_e which, logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(int'(which) * 4);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (which == REG_OWN_ADDR) own_addr_q = value[6:0];
    else bus_en_q = value[0];
    cfg_writes++;
    @(posedge clk_i);
  endtask

  task automatic apb_check(cfg_reg_e which);
    logic [APB_DW-1:0] want;
    want = (which == REG_OWN_ADDR) ? APB_DW'(own_addr_q) : APB_DW'(bus_en_q);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= APB_AW'(int'(which) * 4);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) note_mismatch(which.name(), want, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(logic [6:0] addr, logic en);
    drain();
    apb_write(REG_OWN_ADDR, APB_DW'(addr));
    apb_write(REG_ENABLE, APB_DW'(en));
  endtask

  always @(posedge clk_i) begin
    rsp_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    event_rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      rsp_checked++;
      if (pending_rsp.size() == 0) begin
        note_mismatch("unexpected response", 0, 1);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_if.ack !== want.ack) note_mismatch("ack", want.ack, rsp_if.ack);
        if (rsp_if.tx_byte !== want.tx_byte)
          note_mismatch("tx_byte", want.tx_byte, rsp_if.tx_byte);
        if (rsp_if.host_read_data !== want.host_read_data)
          note_mismatch("host_read_data", want.host_read_data, rsp_if.host_read_data);
        if (rsp_if.pointer_now !== want.pointer_now)
          note_mismatch("pointer_now", want.pointer_now, rsp_if.pointer_now);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("tb: no transaction for %0d cycles, %0d responses outstanding",
               QUIET_MAX, pending_rsp.size());
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic run_reset();
    rst_ni            <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    req_if.valid      <= 1'b0;
    req_if.req_type   <= REQ_OTHER;
    req_if.data       <= '0;
    req_if.host_index <= '0;
    ptr_q      = PTR_NONE;
    own_addr_q = '0;
    bus_en_q   = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      rx_mem[i] = '0;
      tx_mem[i] = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
  endtask

  task automatic test_register_access();
    apb_check(REG_OWN_ADDR);
    apb_check(REG_ENABLE);
    apb_write(REG_OWN_ADDR, 32'h0000_0055);
    apb_check(REG_OWN_ADDR);
    apb_write(REG_OWN_ADDR, 32'hFFFF_FF80);
    apb_check(REG_OWN_ADDR);
    apb_write(REG_OWN_ADDR, 32'h0000_007F);
    apb_check(REG_OWN_ADDR);
    apb_write(REG_ENABLE, 32'h0000_0001);
    apb_check(REG_ENABLE);
    apb_write(REG_ENABLE, 32'hFFFF_FFFE);
    apb_check(REG_ENABLE);
  endtask

  task automatic test_disabled_bus();
    send_event(REQ_ADDR_WR, 8'h00, 8'h00);
    send_event(REQ_BYTE_RX, 8'h03, 8'h00);
    send_event(REQ_BYTE_RX, 8'hC3, 8'h00);
    send_event(REQ_HOST_WR, 8'h77, 8'h03);
    send_event(REQ_ADDR_RD, 8'h00, 8'h00);
    send_event(REQ_BYTE_TX, 8'h00, 8'h00);
    send_event(REQ_OTHER,   8'hFF, 8'hFE);
    send_event(REQ_HOST_RD, 8'h00, 8'h03);
  endtask

  task automatic test_directed_transfers();
    set_config(7'h7F, 1'b1);
    send_event(REQ_HOST_WR, 8'hA5, 8'h00);
    send_event(REQ_HOST_WR, 8'h5A, 8'h01);
    send_event(REQ_HOST_WR, 8'hFF, 8'(DEPTH - 1));
    send_event(REQ_ADDR_WR, 8'h00, 8'h00);
    send_event(REQ_BYTE_RX, 8'h00, 8'h00);
    send_event(REQ_BYTE_RX, 8'hFF, 8'h00);
    send_event(REQ_BYTE_RX, 8'h00, 8'h00);
    send_event(REQ_ADDR_WR, 8'h00, 8'h00);
    send_event(REQ_BYTE_RX, 8'(DEPTH - 2), 8'h00);
    send_event(REQ_BYTE_RX, 8'h81, 8'h00);
    send_event(REQ_BYTE_RX, 8'h7E, 8'h00);
    send_event(REQ_BYTE_RX, 8'h12, 8'h00);
    send_event(REQ_ADDR_RD, 8'h00, 8'h00);
    send_event(REQ_ADDR_WR, 8'h00, 8'h00);
    send_event(REQ_BYTE_RX, 8'h00, 8'h00);
    send_event(REQ_ADDR_RD, 8'h00, 8'h00);
    send_event(REQ_BYTE_TX, 8'h00, 8'h00);
    send_event(REQ_ADDR_WR, 8'h00, 8'h00);
    send_event(REQ_BYTE_RX, 8'(DEPTH - 1), 8'h00);
    send_event(REQ_ADDR_RD, 8'h00, 8'h00);
    send_event(REQ_BYTE_TX, 8'h00, 8'h00);
    send_event(REQ_ADDR_WR, 8'h00, 8'h00);
    send_event(REQ_BYTE_RX, PTR_NONE, 8'h00);
    send_event(REQ_ADDR_RD, 8'h00, 8'h00);
    send_event(REQ_HOST_RD, 8'h00, 8'(DEPTH - 1));
    send_event(REQ_HOST_RD, 8'hFF, 8'h00);
    send_event(REQ_OTHER,   8'h00, 8'h00);
  endtask

  task automatic random_phase(int unsigned count);
    int unsigned stop_at;
    int unsigned sel;
    int unsigned len;
    logic [7:0]  p;
    stop_at = events_sent + count;
    while (events_sent < stop_at) begin
      sel = $urandom_range(99);
      p   = ($urandom_range(19) == 0) ? PTR_NONE : pick_index();
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 8) : $urandom_range(6, 1);
      if (sel < 40) begin
        send_event(REQ_ADDR_WR, 8'($urandom), 8'($urandom_range(DEPTH - 1)));
        send_event(REQ_BYTE_RX, p, 8'($urandom_range(DEPTH - 1)));
        repeat (len) send_event(REQ_BYTE_RX, 8'($urandom), 8'($urandom_range(DEPTH - 1)));
      end else if (sel < 70) begin
        if (sel < 62) begin
          send_event(REQ_ADDR_WR, 8'($urandom), 8'($urandom_range(DEPTH - 1)));
          send_event(REQ_BYTE_RX, p, 8'($urandom_range(DEPTH - 1)));
        end
        send_event(REQ_ADDR_RD, 8'($urandom), 8'($urandom_range(DEPTH - 1)));
        repeat (len) send_event(REQ_BYTE_TX, 8'($urandom), 8'($urandom_range(DEPTH - 1)));
      end else if (sel < 80) begin
        send_event(REQ_HOST_WR, 8'($urandom), pick_index());
      end else if (sel < 90) begin
        send_event(REQ_HOST_RD, 8'($urandom), pick_index());
      end else begin
        send_event(req_e'($urandom_range(REQ_HOST_RD)), 8'($urandom),
                   8'($urandom_range(DEPTH - 1)));
      end
    end
  endtask

  task automatic test_random_traffic();
    set_config(7'h7F, 1'b1);
    calm = 1'b1;
    random_phase(150);
    drain();
    calm = 1'b0;
    set_config(7'($urandom), 1'b1);
    random_phase(400);
    set_config(7'h00, 1'b0);
    random_phase(60);
    set_config(7'($urandom), 1'b1);
    random_phase(200);
  endtask

  initial begin
    calm = 1'b0;
    run_reset();
    test_register_access();
    test_disabled_bus();
    test_directed_transfers();
    test_random_traffic();
    drain();
    repeat (8) @(posedge clk_i);
    $display("tb: %0d events sent, %0d responses checked, %0d register writes",
             events_sent, rsp_checked, cfg_writes);
    $display("tb: per type wr/rx/rd/tx/other/hwr/hrd = %0d/%0d/%0d/%0d/%0d/%0d/%0d, %0d mismatches",
             kind_count[REQ_ADDR_WR], kind_count[REQ_BYTE_RX], kind_count[REQ_ADDR_RD],
             kind_count[REQ_BYTE_TX], kind_count[REQ_OTHER], kind_count[REQ_HOST_WR],
             kind_count[REQ_HOST_RD], mismatches);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/i2ctrb_pkg.sv
sv/i2ctrb_if.sv
sv/i2ctrb_store.sv
sv/i2ctrb_cfg.sv
sv/i2c_target_register_buffer.sv
sv/i2ctrb_checker.sv
verif/tb_i2c_target_register_buffer.sv
